// ===== design/abrc_pkg.sv =====
// ----------------------------------------------------------------------------
// abrc_pkg
// Types, constants and helper functions shared by the selector record checker.
// ----------------------------------------------------------------------------
package abrc_pkg;

  // crc and record layout constants
  localparam logic [31:0] CRC_POLY     = 32'hedb88320;
  localparam logic [31:0] CRC_INIT     = 32'hffffffff;
  localparam logic [31:0] COMMIT_WORD  = 32'h53454c31;
  localparam logic [5:0]  CRC_SPAN     = 6'd28;
  localparam logic [7:0]  PAD_BYTE     = 8'hff;
  localparam logic [5:0]  COMMIT_START = 6'd48;
  localparam logic [5:0]  LAST_POS     = 6'd63;
  localparam logic [5:0]  GEN_END_POS  = 6'd15;
  localparam logic [5:0]  OFS_END_POS  = 6'd23;
  localparam logic [5:0]  SEQ_END_POS  = 6'd27;
  localparam logic [5:0]  CHK_START    = 6'd28;
  localparam logic [5:0]  CHKN_START   = 6'd32;
  localparam logic [5:0]  PAD_START    = 6'd36;
  localparam logic [5:0]  MAGIC_LEN    = 6'd8;

  // verdict codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_CORRUPT = 2'd2
  } status_t;

  // one record byte with its slot
  typedef struct packed {
    logic       slot;
    logic [7:0] record_byte;
  } item_t;

  // one verdict
  typedef struct packed {
    status_t     status;
    logic [31:0] generation;
    logic [31:0] end_offset;
    logic [31:0] sequence_res;
  } result_t;

  // reflected crc-32 update by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // byte k of a word, most significant first
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = w[31:24];
      2'd1:    r = w[23:16];
      2'd2:    r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

  // magic header bytes 'N','B','G',1,0,0,0,0
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h4e;
      3'd1:    r = 8'h42;
      3'd2:    r = 8'h47;
      3'd3:    r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ab_selector_record_checker_top.sv =====
// Byte 63 is held in the input register and its verdict in the result register,
// which drives out_tvalid. One record byte is accepted per cycle while the
// verdict stream is not stalled; the crc byte update and field checks are combinational.
// Reset (synchronous, rst_n low) empties both registers, restarts the record at
// byte 0 and sets data_region_size to zero.
// ----------------------------------------------------------------------------
// ab_selector_record_checker_top
// Checks a 64-byte slot selector record streamed a byte at a time.
// ----------------------------------------------------------------------------
module ab_selector_record_checker_top
  import abrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration: data_region_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // record bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] record_byte
  input  logic [0:0]  in_tuser,   // [0] slot
  // verdicts
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] generation, [63:32] end_offset, [95:64] sequence_res
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  assign cfg_ready = 1'b1;

  // input register
  abrc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // checks and record state
  abrc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  abrc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== design/abrc_in_reg.sv =====
// ----------------------------------------------------------------------------
// abrc_in_reg
// Input register for record bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module abrc_in_reg
  import abrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [0:0] in_tuser,
  input  logic       take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.slot        <= in_tuser[0];
      item_r.record_byte <= in_tdata;
    end
  end

endmodule

// ===== design/abrc_core.sv =====
// ----------------------------------------------------------------------------
// abrc_core
// Per-byte record checks, crc update and field capture; verdict on byte 63.
// ----------------------------------------------------------------------------
module abrc_core
  import abrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  input  item_t       item,
  input  logic        res_ready,
  output logic        take,
  output logic        res_valid,
  output result_t     res
);

  logic [31:0] size_r;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] chk_r, chk_nxt;
  logic [55:0] shift_r;
  logic        gen_hi_nz_r, gen_hi_nz_nxt;
  logic [31:0] gen_lo_r, gen_lo_nxt;
  logic        end_hi_nz_r, end_hi_nz_nxt;
  logic [31:0] end_lo_r, end_lo_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic        corrupt_r, corrupt_nxt;
  logic        empty_r, empty_nxt;
  logic [7:0]  byte_in;
  logic [63:0] shift_full;
  logic        is_last;
  logic        bad;

  assign byte_in    = item.record_byte;
  assign shift_full = {shift_r, byte_in};
  assign is_last    = (pos_r == LAST_POS);
  assign take       = item_valid && (!is_last || res_ready);
  assign res_valid  = item_valid && is_last;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 32'd0;
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end

  // per-byte checks and captures
  always_comb begin
    pos_nxt       = pos_r + 6'd1;
    crc_nxt       = crc_r;
    chk_nxt       = chk_r;
    gen_hi_nz_nxt = gen_hi_nz_r;
    gen_lo_nxt    = gen_lo_r;
    end_hi_nz_nxt = end_hi_nz_r;
    end_lo_nxt    = end_lo_r;
    seq_nxt       = seq_r;
    corrupt_nxt   = corrupt_r;
    empty_nxt     = empty_r;

    if (pos_r < CRC_SPAN) begin
      crc_nxt = crc_byte(crc_r, byte_in);
      if (pos_r == CRC_SPAN - 6'd1) begin
        chk_nxt = ~crc_nxt;
      end
    end

    if (pos_r < MAGIC_LEN) begin
      if (byte_in != magic_byte(pos_r[2:0])) begin
        corrupt_nxt = 1'b1;
      end
    end else if (pos_r == GEN_END_POS) begin
      gen_hi_nz_nxt = (shift_full[63:32] != 32'd0);
      gen_lo_nxt    = shift_full[31:0];
    end else if (pos_r == OFS_END_POS) begin
      end_hi_nz_nxt = (shift_full[63:32] != 32'd0);
      end_lo_nxt    = shift_full[31:0];
    end else if (pos_r == SEQ_END_POS) begin
      seq_nxt = shift_full[31:0];
    end else if (pos_r >= CHK_START && pos_r < CHKN_START) begin
      if (byte_in != word_byte(chk_r, pos_r[1:0])) begin
        corrupt_nxt = 1'b1;
      end
    end else if (pos_r >= CHKN_START && pos_r < PAD_START) begin
      if (byte_in != word_byte(~chk_r, pos_r[1:0])) begin
        corrupt_nxt = 1'b1;
      end
    end else if (pos_r >= COMMIT_START && pos_r < COMMIT_START + 6'd8) begin
      if (byte_in != PAD_BYTE) begin
        empty_nxt = 1'b0;
      end
      if (pos_r < COMMIT_START + 6'd4) begin
        if (byte_in != word_byte(COMMIT_WORD, pos_r[1:0])) begin
          corrupt_nxt = 1'b1;
        end
      end else begin
        if (byte_in != word_byte(~COMMIT_WORD, pos_r[1:0])) begin
          corrupt_nxt = 1'b1;
        end
      end
    end else if (pos_r >= PAD_START) begin
      if (byte_in != PAD_BYTE) begin
        corrupt_nxt = 1'b1;
      end
    end
  end

  // verdict for the last byte
  always_comb begin
    bad = corrupt_nxt || gen_hi_nz_r || (gen_lo_r == 32'd0) ||
          (gen_lo_r[0] != item.slot) || end_hi_nz_r || (end_lo_r > size_r) ||
          (seq_r == 32'd0);
    res.generation   = 32'd0;
    res.end_offset   = 32'd0;
    res.sequence_res = 32'd0;
    if (empty_nxt) begin
      res.status = STATUS_EMPTY;
    end else if (bad) begin
      res.status = STATUS_CORRUPT;
    end else begin
      res.status       = STATUS_OK;
      res.generation   = gen_lo_r;
      res.end_offset   = end_lo_r;
      res.sequence_res = seq_r;
    end
  end

  // record control state, cleared at reset and after each record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 6'd0;
      crc_r     <= CRC_INIT;
      corrupt_r <= 1'b0;
      empty_r   <= 1'b1;
    end else if (take) begin
      if (is_last) begin
        pos_r     <= 6'd0;
        crc_r     <= CRC_INIT;
        corrupt_r <= 1'b0;
        empty_r   <= 1'b1;
      end else begin
        pos_r     <= pos_nxt;
        crc_r     <= crc_nxt;
        corrupt_r <= corrupt_nxt;
        empty_r   <= empty_nxt;
      end
    end
  end

  // captured fields, always written before they are read
  always_ff @(posedge clk) begin
    if (take) begin
      shift_r     <= shift_full[55:0];
      chk_r       <= chk_nxt;
      gen_hi_nz_r <= gen_hi_nz_nxt;
      gen_lo_r    <= gen_lo_nxt;
      end_hi_nz_r <= end_hi_nz_nxt;
      end_lo_r    <= end_lo_nxt;
      seq_r       <= seq_nxt;
    end
  end

endmodule

// ===== design/abrc_out_reg.sv =====
// ----------------------------------------------------------------------------
// abrc_out_reg
// Result register driving the verdict stream.
// ----------------------------------------------------------------------------
module abrc_out_reg
  import abrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  result_t     res,
  output logic        res_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  logic    load;

  assign res_ready  = !valid_r || out_tready;
  assign load       = res_valid && res_ready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.sequence_res, res_r.end_offset, res_r.generation};
  assign out_tuser  = res_r.status;

  // occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== design/abrc_checker.sv =====
// ----------------------------------------------------------------------------
// abrc_checker
// Port-level checks on the verdict stream, bound to the top level.
// ----------------------------------------------------------------------------
module abrc_checker
  import abrc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // no verdict right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("verdict valid after reset");

  // stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled verdict changed");

  // fields are zero unless the record is ok
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_EMPTY || out_tuser == STATUS_CORRUPT)
      |-> out_tdata == 96'd0)
    else $error("fields not cleared on a bad verdict");

  // an ok record has nonzero generation and sequence
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_OK
      |-> out_tdata[31:0] != 32'd0 && out_tdata[95:64] != 32'd0)
    else $error("ok verdict with zero generation or sequence");

endmodule

bind ab_selector_record_checker_top abrc_checker u_abrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/ab_selector_record_checker_top_test.sv =====
// ----------------------------------------------------------------------------
// ab_selector_record_checker_top_test
// Streams 64-byte slot selector records into the checker and compares every
// verdict with a local model of the record checks. A table of hand-built
// records covers the boundaries first, then random records follow, most of
// them well formed with random fields and some damaged or pure noise.
// ----------------------------------------------------------------------------
module ab_selector_record_checker_top_test;
  import abrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DRAIN        = 6;     // cycles past the last verdict
  localparam int          STALL_LIMIT  = 3000;  // cycles with no request at all
  localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int          HOLD_AT      = 24;    // verdict count that starts it
  localparam int          RAND_RECORDS = 7;
  localparam int          PHASE_LEN    = 5;
  localparam int          PAUSE_AT     = 6;
  localparam int          DIR_ROWS     = 22;
  localparam logic [7:0]  NO_FLIP      = 8'hff;
  localparam logic [63:0] MAGIC_HDR    = 64'h4e42_4701_0000_0000;

  typedef logic [63:0][7:0] rec_t;

  // one directed record: register value, fields, damage, pinned verdict
  typedef struct packed {
    logic [31:0] size;
    logic        slot;
    logic [63:0] gen;
    logic [63:0] endo;
    logic [31:0] seq;
    logic [7:0]  flip_pos;
    logic [7:0]  flip_mask;
    logic        blank;
    logic        pinned;
    status_t     status;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] record_byte
  logic [0:0]  in_tuser;   // [0] slot
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // [31:0] generation, [63:32] end_offset, [95:64] sequence_res
  logic [1:0]  out_tuser;  // [1:0] status

  // model state
  logic [31:0] region_size;
  logic [5:0]  rec_pos;
  logic [31:0] crc_run;
  logic [31:0] crc_final;
  logic [63:0] byte_shift;
  logic [63:0] gen_seen;
  logic [63:0] end_seen;
  logic [31:0] seq_seen;
  logic        fmt_bad;
  logic        commit_blank;

  result_t     pending_verdicts[$];
  logic        pin_valid;
  result_t     pin_res;
  int          error_count;
  int          verdicts_seen;
  int          stall_cycles;
  bit          calm;
  dir_row_t    dir_tab [DIR_ROWS];

  ab_selector_record_checker_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    return r;
  endfunction

  // byte k of a word, most significant first
  function automatic logic [7:0] msb_byte(input logic [31:0] w, input int k);
    return w[31 - 8 * k -: 8];
  endfunction

  // well-formed record around the given fields
  function automatic rec_t build_record(input logic [63:0] g, input logic [63:0] e,
                                        input logic [31:0] q);
    rec_t        r;
    logic [31:0] c;
    r = '1;
    for (int k = 0; k < 8; k++) begin
      r[k]      = MAGIC_HDR[63 - 8 * k -: 8];
      r[8 + k]  = g[63 - 8 * k -: 8];
      r[16 + k] = e[63 - 8 * k -: 8];
    end
    for (int k = 0; k < 4; k++) r[24 + k] = msb_byte(q, k);
    c = CRC_INIT;
    for (int k = 0; k < 28; k++) c = crc32_step(c, r[k]);
    c = ~c;
    for (int k = 0; k < 4; k++) begin
      r[28 + k] = msb_byte(c, k);
      r[32 + k] = msb_byte(~c, k);
      r[48 + k] = msb_byte(COMMIT_WORD, k);
      r[52 + k] = msb_byte(~COMMIT_WORD, k);
    end
    return r;
  endfunction

  task automatic restart_record();
    rec_pos      = '0;
    crc_run      = CRC_INIT;
    crc_final    = '0;
    byte_shift   = '0;
    gen_seen     = '0;
    end_seen     = '0;
    seq_seen     = '0;
    fmt_bad      = 1'b0;
    commit_blank = 1'b1;
  endtask

  // advance the record model by one accepted byte
  task automatic predict_byte(input logic s, input logic [7:0] b);
    result_t v;
    int      p;
    p = rec_pos;
    if (p < CRC_SPAN) begin
      crc_run = crc32_step(crc_run, b);
      if (p == CRC_SPAN - 1) crc_final = ~crc_run;
    end
    byte_shift = {byte_shift[55:0], b};
    if (p < MAGIC_LEN) begin
      if (b != MAGIC_HDR[63 - 8 * p -: 8]) fmt_bad = 1'b1;
    end else if (p == GEN_END_POS) begin
      gen_seen = byte_shift;
    end else if (p == OFS_END_POS) begin
      end_seen = byte_shift;
    end else if (p == SEQ_END_POS) begin
      seq_seen = byte_shift[31:0];
    end else if (p >= CHK_START && p < CHKN_START) begin
      if (b != msb_byte(crc_final, p - CHK_START)) fmt_bad = 1'b1;
    end else if (p >= CHKN_START && p < PAD_START) begin
      if (b != msb_byte(~crc_final, p - CHKN_START)) fmt_bad = 1'b1;
    end else if (p >= COMMIT_START && p < COMMIT_START + 8) begin
      if (b != PAD_BYTE) commit_blank = 1'b0;
      if (p < COMMIT_START + 4) begin
        if (b != msb_byte(COMMIT_WORD, p - COMMIT_START)) fmt_bad = 1'b1;
      end else begin
        if (b != msb_byte(~COMMIT_WORD, p - COMMIT_START - 4)) fmt_bad = 1'b1;
      end
    end else if (p >= PAD_START) begin
      if (b != PAD_BYTE) fmt_bad = 1'b1;
    end

    // verdict on the last byte, slot taken from this byte only
    if (p == LAST_POS) begin
      if (commit_blank)
        v = '{STATUS_EMPTY, 32'd0, 32'd0, 32'd0};
      else if (fmt_bad || gen_seen == 64'd0 || gen_seen[63:32] != 32'd0 ||
               gen_seen[0] != s || end_seen > {32'd0, region_size} || seq_seen == 32'd0)
        v = '{STATUS_CORRUPT, 32'd0, 32'd0, 32'd0};
      else
        v = '{STATUS_OK, gen_seen[31:0], end_seen[31:0], seq_seen};
      if (pin_valid) v = pin_res;
      pin_valid = 1'b0;
      pending_verdicts.push_back(v);
      restart_record();
    end else begin
      rec_pos = rec_pos + 6'd1;
    end
  endtask

  // one byte request, with random gaps outside the calm stretch
  task automatic send_byte(input logic s, input logic [7:0] b);
    if (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    predict_byte(s, b);
  endtask

  // earlier bytes carry a random slot, only byte 63 carries the real one
  task automatic send_record(input rec_t r, input logic s);
    for (int i = 0; i < 64; i++)
      send_byte((i == 63) ? s : 1'($urandom_range(1)), r[i]);
  endtask

  // stop sending and wait until every verdict is in and the block is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_size(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    region_size = v;
    cfg_valid <= 1'b0;
  endtask

  // random record: mostly well formed, some twisted fields, damage or noise
  task automatic random_record();
    rec_t        r;
    logic        s;
    logic [63:0] g;
    logic [63:0] e;
    logic [31:0] q;
    int          pick;
    s    = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 12) begin
      for (int i = 0; i < 64; i++) r[i] = $urandom_range(255);
    end else begin
      g    = {32'd0, 32'($urandom())};
      g[0] = s;
      case ($urandom_range(19))
        0:       g = '0;
        1:       g[63:32] = $urandom();
        2:       g[0] = ~s;
        default: ;
      endcase
      e = {32'd0, 32'($urandom_range(region_size))};
      case ($urandom_range(11))
        0:       e = {32'd0, region_size} + 64'd1;
        1:       e[63:32] = $urandom();
        default: ;
      endcase
      q = $urandom();
      if ($urandom_range(19) == 0) q = '0;
      r = build_record(g, e, q);
      if (pick < 27) begin
        for (int k = 48; k < 56; k++) r[k] = PAD_BYTE;
      end
      if ($urandom_range(6) == 0) r[6'($urandom_range(63))] ^= 8'($urandom_range(255, 1));
    end
    send_record(r, s);
  endtask

  task automatic check_verdict();
    result_t want;
    verdicts_seen++;
    if (pending_verdicts.size() == 0) begin
      $error("verdict with none expected: status %0d", out_tuser);
      error_count++;
    end else begin
      want = pending_verdicts.pop_front();
      if (out_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_tuser);
        error_count++;
      end
      if (out_tdata[31:0] !== want.generation) begin
        $error("generation: expected %h, got %h", want.generation, out_tdata[31:0]);
        error_count++;
      end
      if (out_tdata[63:32] !== want.end_offset) begin
        $error("end_offset: expected %h, got %h", want.end_offset, out_tdata[63:32]);
        error_count++;
      end
      if (out_tdata[95:64] !== want.sequence_res) begin
        $error("sequence_res: expected %h, got %h", want.sequence_res, out_tdata[95:64]);
        error_count++;
      end
    end
  endtask

  // verdict receiver with random stalls and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_verdict();
      if (!hold_done && verdicts_seen == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // watchdog on cycles with no request on any channel
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    dir_row_t row;
    rec_t     rec;
    logic [31:0] next_size;

    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    error_count   = 0;
    verdicts_seen = 0;
    calm          = 1'b0;
    pin_valid     = 1'b0;
    pin_res       = '0;
    region_size   = '0;
    restart_record();

    // size, slot, generation, end, sequence, damage, blank, pinned verdict
    dir_tab = '{
      '{32'd0, 1'b1, 64'd1, 64'd0, 32'd1, NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_OK},
      '{32'd0, 1'b0, 64'd2, 64'd1, 32'd7, NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'hffff_ffff, 1'b1, 64'hffff_ffff, 64'hffff_ffff, 32'hffff_ffff,
        NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_OK},
      // zero generation
      '{32'hffff_ffff, 1'b0, 64'd0, 64'd5, 32'd9, NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_CORRUPT},
      // generation wider than 32 bits
      '{32'hffff_ffff, 1'b1, 64'h1_0000_0001, 64'd5, 32'd9,
        NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_CORRUPT},
      // generation parity against slot
      '{32'hffff_ffff, 1'b0, 64'd3, 64'd5, 32'd9, NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_CORRUPT},
      // zero sequence
      '{32'hffff_ffff, 1'b1, 64'd3, 64'd5, 32'd0, NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_CORRUPT},
      // blank commit area wins over a bad header
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd0, 8'h01, 1'b1, 1'b1, STATUS_EMPTY},
      // damaged header, checksum, inverted checksum, padding, commit words
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd3, 8'h80, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd28, 8'h01, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd35, 8'h40, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd40, 8'h01, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd63, 8'hff, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd50, 8'h10, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd54, 8'h02, 1'b0, 1'b1, STATUS_CORRUPT},
      // field byte changed after the checksum was made
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd10, 8'h04, 1'b0, 1'b1, STATUS_CORRUPT},
      // almost blank commit area
      '{32'hffff_ffff, 1'b0, 64'd4, 64'd5, 32'd9, 8'd55, 8'h01, 1'b1, 1'b1, STATUS_CORRUPT},
      // end offset right at and just past the region size
      '{32'd1000, 1'b0, 64'h1234_5678, 64'd1000, 32'h8000_0000,
        NO_FLIP, 8'h00, 1'b0, 1'b0, STATUS_OK},
      '{32'd1000, 1'b1, 64'hdead_beef, 64'd1001, 32'd1, NO_FLIP, 8'h00, 1'b0, 1'b1,
        STATUS_CORRUPT},
      '{32'h8000_0000, 1'b1, 64'hffff_ffff_ffff_ffff, 64'd0, 32'd1,
        NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_CORRUPT},
      '{32'h8000_0000, 1'b0, 64'h7fff_fffe, 64'h7fff_ffff, 32'd2,
        NO_FLIP, 8'h00, 1'b0, 1'b0, STATUS_OK},
      // end offset wider than 32 bits
      '{32'hffff_ffff, 1'b0, 64'hffff_fffe, 64'h1_0000_0000, 32'd3,
        NO_FLIP, 8'h00, 1'b0, 1'b1, STATUS_CORRUPT}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed records
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (i == 0 || row.size != region_size) begin
        settle();
        write_size(row.size);
      end
      rec = build_record(row.gen, row.endo, row.seq);
      if (row.blank) begin
        for (int k = 48; k < 56; k++) rec[k] = PAD_BYTE;
      end
      if (row.flip_pos != NO_FLIP) rec[row.flip_pos[5:0]] ^= row.flip_mask;
      if (row.pinned) begin
        pin_valid = 1'b1;
        pin_res   = '{row.status, 32'd0, 32'd0, 32'd0};
        if (row.status == STATUS_OK)
          pin_res = '{STATUS_OK, row.gen[31:0], row.endo[31:0], row.seq};
      end
      send_record(rec, row.slot);
    end

    // random records in phases of register settings
    for (int n = 0; n < RAND_RECORDS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case (n / PHASE_LEN)
          0:       next_size = 32'hffff_ffff;
          1:       next_size = $urandom_range(4096);
          2:       next_size = 32'd0;
          default: next_size = $urandom();
        endcase
        settle();
        write_size(next_size);
      end
      if (n == PAUSE_AT) settle();
      calm = (n >= 1 && n < 5);
      random_record();
    end
    calm = 1'b0;

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
